// ===== rtl/uac_pkg.sv =====
// Shared widths, state codes and a helper function of the unbiased autocorrelation unit.
`timescale 1ns / 1ps
`default_nettype none

package uac_pkg;

   // Sample store depth and the fixed field widths.
   localparam int MAX_SAMPLES = 64;
   localparam int SAMPLE_W    = 16;
   localparam int LAG_W       = 7;
   localparam int ACF_W       = 33;

   // Derived datapath widths.
   localparam int COUNT_W   = $clog2(MAX_SAMPLES + 1);
   localparam int ADDR_W    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int SUM_W     = SAMPLE_W + COUNT_W - 1;
   localparam int DEV_W     = SAMPLE_W + COUNT_W + 1;
   localparam int PROD_W    = 2 * DEV_W;
   localparam int ACC_W     = PROD_W + COUNT_W;
   localparam int NSQ_W     = 2 * COUNT_W;
   localparam int DIVISOR_W = 3 * COUNT_W;
   localparam int REM_W     = DIVISOR_W + 1;
   localparam int STEP_W    = $clog2(ACF_W);

   // The factor 4/5 is applied as 820/1024, which is exact for counts up to 64.
   localparam int LAG_NUM   = 820;
   localparam int LAG_SHIFT = 10;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SETUP,
      ST_MAC,
      ST_DRAIN,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

   // Status returned by the divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Highest lag computed for a block of n samples: floor(4n/5).
   function automatic logic [COUNT_W-1:0] max_lag_of(input logic [COUNT_W-1:0] n);
      logic [COUNT_W+LAG_SHIFT-1:0] scaled;
      scaled = (COUNT_W + LAG_SHIFT)'(n) * (COUNT_W + LAG_SHIFT)'(LAG_NUM);
      return scaled[LAG_SHIFT +: COUNT_W];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/uac_req_if.sv =====
// Input channel interface carrying one sample per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface uac_req_if;
   import uac_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       is_last;

   modport source (output valid, output sample, output is_last, input ready);
   modport sink   (input valid, input sample, input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/uac_rsp_if.sv =====
// Result channel interface carrying one autocorrelation lag per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface uac_rsp_if;
   import uac_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [LAG_W-1:0]        lag;
   logic signed [ACF_W-1:0] acf_value;
   logic                    dropped;
   logic                    last_lag;

   modport source (output valid, output lag, output acf_value, output dropped,
                   output last_lag, input ready);
   modport sink   (input valid, input lag, input acf_value, input dropped,
                   input last_lag, output ready);
endinterface

`default_nettype wire

// ===== rtl/uac_divider.sv =====
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none

module uac_divider (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic signed [uac_pkg::ACC_W-1:0] dividend,
   input  wire logic [uac_pkg::DIVISOR_W-1:0]    divisor,
   output uac_pkg::div_status_type               status,
   output logic signed [uac_pkg::ACF_W-1:0]      quotient
);
   import uac_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 neg_ff, neg_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [ACF_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] den_ff, den_in;
   logic [ACC_W-1:0]     mag;
   logic [REM_W-1:0]     trial;

   // The quotient is known to fit in ACF_W bits, so the high dividend bits are
   // preloaded as the first partial remainder and only ACF_W steps remain.
   always_comb begin
      mag     = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
      trial   = {rem_ff[DIVISOR_W-1:0], quo_ff[ACF_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = dividend[ACC_W-1];
         rem_in  = REM_W'(mag >> ACF_W);
         quo_in  = mag[ACF_W-1:0];
         den_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[ACF_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[ACF_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(ACF_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
   end

   // Restore the sign of the truncated quotient.
   assign quotient    = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ===== rtl/unbiased_autocorrelation_unit.sv =====
// Top level: sample store, lag sequencer, shared multiply-accumulate and divider.
//
//   Channel  Direction  Transaction carries
//   req_ch   in         sample (Q8.8), is_last
//   rsp_ch   out        lag, acf_value (Q16.16), dropped, last_lag
//
// A sample that is not marked last is taken as soon as it is offered.
// On the last sample, each lag k runs (n-k) products through the shared multiplier,
// then the pipeline drains, the bit-serial divider is started and run, and the
// result transaction is offered.
// req_ch.ready is low from the last sample until the final result is taken;
// a stalled result holds the sequencer in place. Synchronous reset empties the block.
`timescale 1ns / 1ps
`default_nettype none

module unbiased_autocorrelation_unit (
   input wire logic clock,
   input wire logic reset,
   uac_req_if.sink   req_ch,
   uac_rsp_if.source rsp_ch
);
   import uac_pkg::*;

   state_type               state_ff, state_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    ovf_ff, ovf_in;
   logic [COUNT_W-1:0]      idx_ff, idx_in;
   logic [COUNT_W-1:0]      lag_ff, lag_in;
   logic [COUNT_W-1:0]      max_lag_ff, max_lag_in;
   logic [NSQ_W-1:0]        nsq_ff, nsq_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   logic                    p1_ff, p2_ff, p3_ff;
   logic signed [SAMPLE_W-1:0] rd_a_ff, rd_b_ff;
   logic signed [DEV_W-1:0] dev_a_ff, dev_b_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LAG_W-1:0]        rsp_lag_ff;
   logic signed [ACF_W-1:0] rsp_acf_ff;
   logic                    rsp_dropped_ff;
   logic                    rsp_last_ff;
   logic                    capture;

   logic signed [SAMPLE_W-1:0] store [MAX_SAMPLES];
   logic                    store_we;
   logic                    issue;
   logic [ADDR_W-1:0]       addr_a, addr_b;
   logic [COUNT_W-1:0]      span;
   logic signed [COUNT_W:0] n_signed;

   logic                    div_start;
   logic [DIVISOR_W-1:0]    div_divisor;
   div_status_type          div_status;
   logic signed [ACF_W-1:0] div_quotient;

   logic                    req_fire, rsp_fire;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_valid_ff && rsp_ch.ready;
   assign span     = count_ff - lag_ff;
   assign n_signed = signed'({1'b0, count_ff});
   assign addr_a   = idx_ff[ADDR_W-1:0];
   assign addr_b   = ADDR_W'(idx_ff + lag_ff);
   assign div_divisor = DIVISOR_W'(nsq_ff) * DIVISOR_W'(span);

   // Sequencer: next state and control.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      lag_in       = lag_ff;
      max_lag_in   = max_lag_ff;
      nsq_in       = nsq_ff;
      acc_in       = p3_ff ? acc_ff + ACC_W'(prod_ff) : acc_ff;
      rsp_valid_in = rsp_valid_ff;
      store_we     = 1'b0;
      issue        = 1'b0;
      div_start    = 1'b0;
      capture      = 1'b0;
      req_ch.ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               if (count_ff < COUNT_W'(MAX_SAMPLES)) begin
                  store_we = 1'b1;
                  count_in = count_ff + 1'b1;
                  sum_in   = sum_ff + SUM_W'(req_ch.sample);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_ch.is_last) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            nsq_in     = NSQ_W'(count_ff) * NSQ_W'(count_ff);
            max_lag_in = max_lag_of(count_ff);
            lag_in     = '0;
            idx_in     = '0;
            acc_in     = '0;
            state_in   = ST_MAC;
         end
         ST_MAC: begin
            issue  = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == span - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p1_ff && !p2_ff && !p3_ff) begin
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               capture      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               if (lag_ff == max_lag_ff) begin
                  count_in = '0;
                  sum_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  lag_in   = lag_ff + 1'b1;
                  idx_in   = '0;
                  acc_in   = '0;
                  state_in = ST_MAC;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         p3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         p1_ff        <= issue;
         p2_ff        <= p1_ff;
         p3_ff        <= p2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequencer datapath registers.
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      lag_ff     <= lag_in;
      max_lag_ff <= max_lag_in;
      nsq_ff     <= nsq_in;
      acc_ff     <= acc_in;
   end

   // Sample store: one write port while loading, two registered read ports.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store[count_ff[ADDR_W-1:0]] <= req_ch.sample;
      end
      rd_a_ff <= store[addr_a];
      rd_b_ff <= store[addr_b];
   end

   // Shared multiply-accumulate pipeline: deviations n*x - S, then their product.
   always_ff @(posedge clock) begin
      dev_a_ff <= DEV_W'(n_signed) * DEV_W'(rd_a_ff) - DEV_W'(sum_ff);
      dev_b_ff <= DEV_W'(n_signed) * DEV_W'(rd_b_ff) - DEV_W'(sum_ff);
      prod_ff  <= PROD_W'(dev_a_ff) * PROD_W'(dev_b_ff);
   end

   // Each lag sum is divided by n*n*(n-k).
   uac_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Result register, held until the transaction completes.
   always_ff @(posedge clock) begin
      if (capture) begin
         rsp_lag_ff     <= LAG_W'(lag_ff);
         rsp_acf_ff     <= div_quotient;
         rsp_dropped_ff <= ovf_ff;
         rsp_last_ff    <= (lag_ff == max_lag_ff);
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.lag       = rsp_lag_ff;
   assign rsp_ch.acf_value = rsp_acf_ff;
   assign rsp_ch.dropped   = rsp_dropped_ff;
   assign rsp_ch.last_lag  = rsp_last_ff;

   // A result is never offered while samples are being taken.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid_ff && req_ch.ready))
      else $error("Result offered while the input channel is ready.");

   // The sample count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_SAMPLES))
      else $error("Sample count exceeds the store depth.");

   // Lags stay within the computed range, and all stored reads are below the count.
   a_lag_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (lag_ff <= max_lag_ff && idx_ff + lag_ff < count_ff))
      else $error("Lag or store index out of range.");

   // The divider is idle whenever a new division starts.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("Divider started while busy.");

   // Taking the final result returns the block to loading with an empty store.
   a_block_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last_ff) |=> (state_ff == ST_LOAD && count_ff == '0 && !ovf_ff))
      else $error("Block did not restart after its final result.");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the unbiased autocorrelation unit.
`timescale 1ns / 1ps

module tb;
   import uac_pkg::*;

   // Idling modes of the random part; each block of samples carries one.
   typedef enum logic [1:0] {
      MODE_STEADY,
      MODE_SPARSE_IN,
      MODE_SLOW_OUT,
      MODE_BOTH
   } idle_mode_type;

   // One pending sample transaction and the pacing hints that travel with it.
   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       is_last;
      idle_mode_type              mode;
      bit                         wait_drained;
      bit                         hold_after;
   } sample_item_type;

   // One expected lag result.
   typedef struct packed {
      logic [LAG_W-1:0]        lag;
      logic signed [ACF_W-1:0] acf_value;
      logic                    dropped;
      logic                    last_lag;
   } lag_result_type;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam int HOLDOFF_CYCLES = 400;
   localparam int SETTLE_CYCLES  = 300;
   localparam int RANDOM_BUDGET  = 10;

   logic clock;
   logic reset;

   uac_req_if req_if ();
   uac_rsp_if rsp_if ();

   unbiased_autocorrelation_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Stimulus queue and the predicted lag results.
   sample_item_type sample_queue[$];
   lag_result_type  acf_expected[$];

   // Shadow copy of the block's sample store.
   logic signed [SAMPLE_W-1:0] held_samples [MAX_SAMPLES];
   int  held_count    = 0;
   bit  block_dropped = 1'b0;

   // Progress counters; the ones read by other processes change by nonblocking update.
   int  total_items  = 0;
   int  total_blocks = 0;
   int  lags_owed    = 0;
   int  owed_total   = 0;
   int  sent_count   = 0;
   int  lags_checked = 0;
   int  fail_count   = 0;
   bit  cur_hold     = 1'b0;
   bit  hold_go      = 1'b0;
   bit  rsp_holdoff  = 1'b0;
   idle_mode_type run_mode = MODE_STEADY;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Runaway guard.
   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic int send_idle_pct(idle_mode_type m);
      case (m)
         MODE_SPARSE_IN: return 86;
         MODE_BOTH:      return 32;
         default:        return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct(idle_mode_type m);
      case (m)
         MODE_SLOW_OUT: return 86;
         MODE_BOTH:     return 32;
         default:       return 0;
      endcase
   endfunction

   // Sample values lean toward the extremes and small magnitudes.
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int style;
      style = $urandom_range(9);
      case (style)
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2, 3, 4: return SAMPLE_W'($urandom_range(1024)) - SAMPLE_W'(512);
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   task automatic push_item(input logic signed [SAMPLE_W-1:0] s, input bit fin,
                            input idle_mode_type m, input bit drained, input bit hold);
      sample_item_type it;
      it.sample       = s;
      it.is_last      = fin;
      it.mode         = m;
      it.wait_drained = drained;
      it.hold_after   = hold;
      sample_queue.push_back(it);
      total_items++;
      if (fin) total_blocks++;
   endtask

   // A block of len samples; now and then every sample of the block is the same.
   task automatic add_block(input int len, input idle_mode_type m, input bit drained,
                            input bit hold);
      logic signed [SAMPLE_W-1:0] flat_value;
      bit flat;
      flat       = ($urandom_range(9) == 0);
      flat_value = pick_sample();
      for (int i = 0; i < len; i++) begin
         push_item(flat ? flat_value : pick_sample(), i == len - 1, m,
                   drained && i == 0, hold && i == len - 1);
      end
   endtask

   // Store or drop one sample; on the last one, predict every lag of the block.
   task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] s, input logic fin);
      longint dev [MAX_SAMPLES];
      longint n, total, acc, divisor, quotient;
      int top;
      lag_result_type r;
      if (held_count < MAX_SAMPLES) begin
         held_samples[held_count] = s;
         held_count++;
      end else begin
         block_dropped = 1'b1;
      end
      if (fin) begin
         n     = held_count;
         total = 0;
         for (int i = 0; i < held_count; i++) total += longint'(held_samples[i]);
         // Scaled deviations n*x - S keep the mean removal exact.
         for (int i = 0; i < held_count; i++) dev[i] = n * longint'(held_samples[i]) - total;
         top = (4 * held_count) / 5;
         for (int k = 0; k <= top; k++) begin
            acc = 0;
            for (int i = 0; i + k < held_count; i++) acc += dev[i] * dev[i + k];
            divisor     = n * n * (n - k);
            quotient    = acc / divisor;
            r.lag       = LAG_W'(k);
            r.acf_value = quotient[ACF_W-1:0];
            r.dropped   = block_dropped;
            r.last_lag  = (k == top);
            acf_expected.push_back(r);
            lags_owed++;
         end
         held_count    = 0;
         block_dropped = 1'b0;
      end
   endtask

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // Request driver: holds each transaction until it is taken, may idle between them.
   always @(posedge clock) begin : req_driver
      sample_item_type it;
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.sample  <= '0;
         req_if.is_last <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            absorb_sample(req_if.sample, req_if.is_last);
            sent_count <= sent_count + 1;
            owed_total <= lags_owed;
            if (cur_hold) hold_go <= 1'b1;
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (sample_queue.size() != 0 &&
                (!sample_queue[0].wait_drained || lags_owed == lags_checked) &&
                $urandom_range(99) >= send_idle_pct(run_mode)) begin
               it       = sample_queue.pop_front();
               cur_hold = it.hold_after;
               req_if.valid   <= 1'b1;
               req_if.sample  <= it.sample;
               req_if.is_last <= it.is_last;
               run_mode       <= it.mode;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each transaction against the oldest prediction.
   always @(posedge clock) begin : rsp_monitor
      lag_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (acf_expected.size() == 0) begin
               log_failure($sformatf("unexpected result: lag %0d acf %0d",
                                     rsp_if.lag, rsp_if.acf_value));
            end else begin
               want = acf_expected.pop_front();
               lags_checked <= lags_checked + 1;
               if (rsp_if.lag !== want.lag || rsp_if.acf_value !== want.acf_value ||
                   rsp_if.dropped !== want.dropped || rsp_if.last_lag !== want.last_lag) begin
                  log_failure($sformatf(
                     "mismatch: expected lag %0d acf %0d dropped %0b last %0b, %s",
                     want.lag, want.acf_value, want.dropped, want.last_lag,
                     $sformatf("got lag %0d acf %0d dropped %0b last %0b", rsp_if.lag,
                               rsp_if.acf_value, rsp_if.dropped, rsp_if.last_lag)));
               end
            end
         end
         rsp_if.ready <= !rsp_holdoff && ($urandom_range(99) >= recv_stall_pct(run_mode));
      end
   end

   // Long output stall once the flagged block has been sent, so the next block backs up.
   initial begin : rsp_holdoff_ctl
      @(posedge clock);
      while (!hold_go) @(posedge clock);
      rsp_holdoff <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      rsp_holdoff <= 1'b0;
   end

   // Stimulus build, reset and end of run.
   initial begin : run_control
      int budget;
      int len;
      reset = 1'b1;

      // Directed blocks: single extreme samples, a two-sample swing, alternating
      // extremes with a nonzero mean, a flat block and small values of both signs.
      push_item(SAMPLE_MAX, 1'b1, MODE_STEADY, 1'b0, 1'b0);
      push_item(SAMPLE_MIN, 1'b1, MODE_STEADY, 1'b0, 1'b0);
      push_item(SAMPLE_MIN, 1'b0, MODE_STEADY, 1'b1, 1'b0);
      push_item(SAMPLE_MAX, 1'b1, MODE_STEADY, 1'b0, 1'b0);
      push_item(SAMPLE_MAX, 1'b0, MODE_STEADY, 1'b0, 1'b0);
      push_item(SAMPLE_MIN, 1'b0, MODE_STEADY, 1'b0, 1'b0);
      push_item(SAMPLE_MAX, 1'b0, MODE_STEADY, 1'b0, 1'b0);
      push_item(SAMPLE_MIN, 1'b0, MODE_STEADY, 1'b0, 1'b0);
      push_item(16'sd0, 1'b1, MODE_STEADY, 1'b0, 1'b0);
      for (int i = 0; i < 4; i++) push_item(16'sh0100, i == 3, MODE_STEADY, 1'b0, 1'b0);
      push_item(16'sd3, 1'b0, MODE_STEADY, 1'b0, 1'b0);
      push_item(-16'sd1, 1'b0, MODE_STEADY, 1'b0, 1'b0);
      push_item(16'sd4, 1'b0, MODE_STEADY, 1'b0, 1'b0);
      push_item(-16'sd1, 1'b0, MODE_STEADY, 1'b0, 1'b0);
      push_item(16'sd5, 1'b0, MODE_STEADY, 1'b0, 1'b0);
      push_item(-16'sd9, 1'b0, MODE_STEADY, 1'b0, 1'b0);
      push_item(16'sd2, 1'b1, MODE_STEADY, 1'b0, 1'b0);

      // Random blocks in each idling mode; mostly short, plus a full and an
      // overflowing store and one block followed by a long output stall.
      for (int m = 0; m < 4; m++) begin
         budget = RANDOM_BUDGET;
         add_block($urandom_range(1, 9), idle_mode_type'(m), 1'b1, 1'b0);
         while (budget > 0) begin
            len = $urandom_range(1, 9);
            add_block(len, idle_mode_type'(m), 1'b0, 1'b0);
            budget -= len;
         end
         if (idle_mode_type'(m) == MODE_STEADY) begin
            add_block(MAX_SAMPLES, MODE_STEADY, 1'b0, 1'b0);
            add_block(8, MODE_STEADY, 1'b1, 1'b1);
            add_block(5, MODE_STEADY, 1'b0, 1'b0);
         end
         if (idle_mode_type'(m) == MODE_BOTH)
            add_block(MAX_SAMPLES + 2, MODE_BOTH, 1'b0, 1'b0);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (sent_count != total_items || owed_total != lags_checked) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (acf_expected.size() != 0)
         log_failure($sformatf("%0d expected results never arrived", acf_expected.size()));
      $display("Checked %0d lag results from %0d samples in %0d blocks.",
               lags_checked, total_items, total_blocks);
      $display("Covered full and overflowed stores, all idling modes and a long output stall.");
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/uac_pkg.sv
rtl/uac_req_if.sv
rtl/uac_rsp_if.sv
rtl/uac_divider.sv
rtl/unbiased_autocorrelation_unit.sv
dv/tb.sv
